### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the color key scan block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/ckbc_pkg.sv
// Package with constants, types and the pixel packing function of the color key scan block.
package ckbc_pkg;

    localparam int MAX_DIM = 2048;
    localparam int COORD_W = $clog2(MAX_DIM);
    localparam int DIM_W   = COORD_W + 1;
    localparam int PIX_W   = 16;
    localparam int WORD_W  = 32;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [DIM_W-1:0] DIM_MAX      = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] DIM_ONE      = DIM_W'(1);
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
    localparam logic [PIX_W-1:0] KEY_RESET    = 16'h07FF;
    localparam logic [WORD_W-1:0] KEY_WORD    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_KEY_COLOR    = 2'd2,
        REG_NONE         = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic              done;
        logic              valid;
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] min_y;
        logic [DIM_W-1:0]   end_x;
        logic [DIM_W-1:0]   end_y;
    } t_box;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_ONE;
        end else if (v > DIM_MAX) begin
            r = DIM_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pack565(input logic [PIX_W-1:0] p);
        return {8'h00, p[4:0], 3'b000, p[10:5], 2'b00, p[15:8]};
    endfunction

endpackage

### rtl/color_key_scan_bbox_convert_top.sv
// Color key scan: 565 to 32-bit pixel conversion with bounding box of non-key pixels.
//
// Pixels enter in raster order, one beat per pixel, and each leaves as one 32-bit word:
// all ones for the key color, else blue in bits 23:19, green in 15:10 and the upper
// pixel byte in 7:0. One pixel is taken every cycle while o_in_stall is low; a pixel passes
// through an input register and a result register, and the input register can take a new
// pixel while the previous result is stalled, if the input register is empty. On the
// last pixel of a frame (frame_width by frame_height, zero acting as one and values
// above 2048 as 2048) frame_done is set together with the box of non-key pixels
// (end exclusive), box_valid if any non-key pixel was seen; the scan state clears.
// Registers: frame_width at 0x0, frame_height at 0x4, key_color at 0x8; write them
// only while no beat is in flight.
`include "assert_macros.svh"

module color_key_scan_bbox_convert_top
    import ckbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PIX_W-1:0]     i_pixel_in,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [WORD_W-1:0]    o_pixel_out,
    output logic                 o_frame_done,
    output logic                 o_box_valid,
    output logic [COORD_W-1:0]   o_box_min_x,
    output logic [COORD_W-1:0]   o_box_min_y,
    output logic [DIM_W-1:0]     o_box_end_x,
    output logic [DIM_W-1:0]     o_box_end_y
);

    logic [DIM_W-1:0]   r_frame_width;
    logic [DIM_W-1:0]   r_frame_height;
    logic [PIX_W-1:0]   r_key_color;

    logic               r_s1_valid;
    logic [PIX_W-1:0]   r_pixel;

    logic [COORD_W-1:0] r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic [DIM_W-1:0]   r_least_x, n_least_x;
    logic [DIM_W-1:0]   r_least_y, n_least_y;
    logic [COORD_W-1:0] r_great_x, n_great_x;
    logic [COORD_W-1:0] r_great_y, n_great_y;

    logic               r_out_valid;
    logic [WORD_W-1:0]  r_word, n_word;
    t_box               r_box, n_box;

    logic               advance;
    logic               s1_fire;
    logic               cfg_wr;
    t_reg_idx           reg_idx;
    logic [DIM_W-1:0]   lim_w;
    logic [DIM_W-1:0]   lim_h;
    logic               is_key;
    logic               last_col;
    logic               done;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            REG_KEY_COLOR:    prdata = APB_DW'(r_key_color);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
            r_key_color    <= KEY_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[DIM_W-1:0];
                REG_KEY_COLOR:    r_key_color    <= pwdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Flow control: result register frees when empty or taken.
    assign advance    = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && advance;
    assign o_in_stall = r_s1_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_pixel <= i_pixel_in;
        end
    end

    assign lim_w    = clamp_dim(r_frame_width);
    assign lim_h    = clamp_dim(r_frame_height);
    assign is_key   = (r_pixel == r_key_color);
    assign last_col = ({1'b0, r_col} + DIM_ONE) >= lim_w;
    assign done     = last_col && (({1'b0, r_row} + DIM_ONE) >= lim_h);

    always_comb begin
        n_word    = is_key ? KEY_WORD : pack565(r_pixel);
        n_great_x = r_great_x;
        n_great_y = r_great_y;
        n_least_x = r_least_x;
        n_least_y = r_least_y;
        if (!is_key) begin
            if (r_col > r_great_x)          n_great_x = r_col;
            if (r_row > r_great_y)          n_great_y = r_row;
            if ({1'b0, r_col} < r_least_x)  n_least_x = {1'b0, r_col};
            if ({1'b0, r_row} < r_least_y)  n_least_y = {1'b0, r_row};
        end

        n_box       = '0;
        n_box.done  = done;
        if (done && (n_least_x <= {1'b0, n_great_x})) begin
            n_box.valid = 1'b1;
            n_box.min_x = n_least_x[COORD_W-1:0];
            n_box.min_y = n_least_y[COORD_W-1:0];
            n_box.end_x = {1'b0, n_great_x} + DIM_ONE;
            n_box.end_y = {1'b0, n_great_y} + DIM_ONE;
        end

        n_col = r_col + COORD_W'(1);
        n_row = r_row;
        if (done) begin
            n_col     = '0;
            n_row     = '0;
            n_least_x = DIM_MAX;
            n_least_y = DIM_MAX;
            n_great_x = '0;
            n_great_y = '0;
        end else if (last_col) begin
            n_col = '0;
            n_row = r_row + COORD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_least_x <= DIM_MAX;
            r_least_y <= DIM_MAX;
            r_great_x <= '0;
            r_great_y <= '0;
        end else if (s1_fire) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_least_x <= n_least_x;
            r_least_y <= n_least_y;
            r_great_x <= n_great_x;
            r_great_y <= n_great_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_word <= n_word;
            r_box  <= n_box;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_word;
    assign o_frame_done = r_box.done;
    assign o_box_valid  = r_box.valid;
    assign o_box_min_x  = r_box.min_x;
    assign o_box_min_y  = r_box.min_y;
    assign o_box_end_x  = r_box.end_x;
    assign o_box_end_y  = r_box.end_y;

    `ASSERT_SAME(a_box_only_at_end, i_clk, i_rst_n, o_out_valid && o_box_valid, o_frame_done)
    `ASSERT_NEXT(a_clear_after_end, i_clk, i_rst_n, s1_fire && done, (r_col == '0) && (r_row == '0) && (r_least_x == DIM_MAX))
    `ASSERT_SAME(a_least_in_range, i_clk, i_rst_n, 1'b1, (r_least_x <= DIM_MAX) && (r_least_y <= DIM_MAX))

endmodule
